### rtl/gzsb_pkg.sv
// Package for the guard zone shadow bitmap: sizes, command codes and the
// payload and queue entry types. No dependencies.
package gzsb_pkg;

  localparam int ADDR_WIDTH = 16;
  localparam int PAGE_SHIFT = 12;
  localparam int WORD_BITS  = 64;

  localparam int LEN_W          = ADDR_WIDTH + 1;
  localparam int GRAN_BITS      = 3;
  localparam int BIT_W          = $clog2(WORD_BITS);
  localparam int TAKE_W         = BIT_W + 1;
  localparam int WIDX_W         = ADDR_WIDTH - BIT_W;
  localparam int NUM_WORDS      = 1 << WIDX_W;
  localparam int PAGE_W         = ADDR_WIDTH - PAGE_SHIFT;
  localparam int NUM_PAGES      = 1 << PAGE_W;
  localparam int PWORD_W        = PAGE_SHIFT - BIT_W;
  localparam int QUEUE_DEPTH    = 2;
  localparam int QPTR_W         = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    OP_CHECK  = 2'd0,
    OP_MARK   = 2'd1,
    OP_UNMARK = 2'd2,
    OP_ALLOC  = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0]            command;
    logic [ADDR_WIDTH-1:0] address;
    logic [LEN_W-1:0]      length;
  } in_item_t;

  typedef struct packed {
    logic guard_hit;
    logic page_missing;
  } out_item_t;

  typedef struct packed {
    op_t                   op;
    logic [ADDR_WIDTH-1:0] addr;
    logic [LEN_W-1:0]      len;
  } cmd_t;

endpackage

### rtl/guard_zone_shadow_bitmap_top.sv
// Top level of the guard zone shadow bitmap: front end, command queue and
// back end. Depends on gzsb_pkg, gzsb_front, gzsb_queue and gzsb_back.
//
// A check issues the registered RAM read as it is taken, samples the bit and
// then registers the result; the back end takes no new command until then.
// Mark and unmark read and then write back each bitmap word in a valid page
// and only step past each word in a missing page. Allocating a new page
// writes one zero word per word of the page (64 here).
// Reset clears the page flags, the command queue and the result valid flag;
// the bitmap RAM is not cleared, since allocation zeroes a page before use.
module guard_zone_shadow_bitmap_top import gzsb_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  output logic      full,
  input  in_item_t  in_data,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_data
);

  logic q_push, q_full, q_pop, q_empty;
  cmd_t q_wr_data, q_rd_data;
  logic out_valid;

  // The front end classifies each request and aligns range commands, so the
  // back end only sees clean, 8-aligned ranges.
  gzsb_front u_front (
    .push    (push),
    .full    (full),
    .in_data (in_data),
    .q_push  (q_push),
    .q_data  (q_wr_data),
    .q_full  (q_full)
  );

  // The queue lets new requests be taken while the back end is busy walking
  // words or waiting for its result to be popped.
  gzsb_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_push),
    .wr_data (q_wr_data),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (q_rd_data),
    .empty   (q_empty)
  );

  // The back end owns the page flags and the bitmap RAM and runs one
  // command at a time, ending with a single result per command.
  gzsb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_data    (q_rd_data),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_pop   (pop)
  );

  assign empty = ~out_valid;

endmodule

### rtl/gzsb_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module gzsb_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

### rtl/gzsb_front.sv
// Front end: accepts input items and turns them into queue commands.
// Depends on gzsb_pkg.
module gzsb_front import gzsb_pkg::*; (
  input  logic     push,
  output logic     full,
  input  in_item_t in_data,
  output logic     q_push,
  output cmd_t     q_data,
  input  logic     q_full
);

  op_t op;

  assign op     = op_t'(in_data.command);
  assign full   = q_full;
  assign q_push = push & ~q_full;

  // Range commands drop the low address and length bits; checks and
  // allocations keep the address as given.
  always_comb begin
    q_data.op   = op;
    q_data.addr = in_data.address;
    q_data.len  = '0;
    if (op == OP_MARK || op == OP_UNMARK) begin
      q_data.addr = {in_data.address[ADDR_WIDTH-1:GRAN_BITS], {GRAN_BITS{1'b0}}};
      q_data.len  = {in_data.length[LEN_W-1:GRAN_BITS], {GRAN_BITS{1'b0}}};
    end
  end

endmodule

### rtl/gzsb_queue.sv
// Short command queue between the front end and the back end.
// Depends on gzsb_pkg.
module gzsb_queue import gzsb_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_en,
  input  cmd_t wr_data,
  output logic full,
  input  logic rd_en,
  output cmd_t rd_data,
  output logic empty
);

  cmd_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   count_r, count_nxt;
  logic              do_wr, do_rd;

  assign full    = (count_r == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign rd_data = mem_r[rd_ptr_r];
  assign do_wr   = wr_en & ~full;
  assign do_rd   = rd_en & ~empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

### rtl/gzsb_back.sv
// Back end: executes commands against the page flags and the bitmap RAM
// and holds the result register. Depends on gzsb_pkg and gzsb_ram.
module gzsb_back import gzsb_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cmd_t      q_data,
  input  logic      q_empty,
  output logic      q_pop,
  output logic      out_valid,
  output out_item_t out_data,
  input  logic      out_pop
);

  typedef enum logic [5:0] {
    ST_IDLE     = 6'b000001,
    ST_CHK_WAIT = 6'b000010,
    ST_CLEAR    = 6'b000100,
    ST_WALK     = 6'b001000,
    ST_MODIFY   = 6'b010000,
    ST_REPORT   = 6'b100000
  } state_t;

  state_t                state_r, state_nxt;
  op_t                   op_r, op_nxt;
  logic [ADDR_WIDTH-1:0] a_r, a_nxt;
  logic [LEN_W-1:0]      rem_r, rem_nxt;
  logic [PWORD_W-1:0]    clr_cnt_r, clr_cnt_nxt;
  logic                  hit_r, hit_nxt;
  logic                  miss_r, miss_nxt;
  logic [NUM_PAGES-1:0]  page_valid_r, page_valid_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_data_r, out_data_nxt;

  logic                  ram_wr_en, ram_rd_en;
  logic [WIDX_W-1:0]     ram_wr_addr, ram_rd_addr;
  logic [WORD_BITS-1:0]  ram_wr_data, ram_rd_data;

  logic [PAGE_W-1:0]     cur_page;
  logic [BIT_W-1:0]      bit_off;
  logic [TAKE_W-1:0]     room, take, span_end;
  logic [WORD_BITS-1:0]  mask;
  logic                  last_word;

  gzsb_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (NUM_WORDS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // Span of the current range within the word that holds a_r.
  assign cur_page  = a_r[ADDR_WIDTH-1:PAGE_SHIFT];
  assign bit_off   = a_r[BIT_W-1:0];
  assign room      = TAKE_W'(WORD_BITS) - {1'b0, bit_off};
  assign take      = (rem_r < LEN_W'(room)) ? rem_r[TAKE_W-1:0] : room;
  assign span_end  = {1'b0, bit_off} + take;
  assign last_word = (rem_r == LEN_W'(take));

  always_comb begin
    for (int i = 0; i < WORD_BITS; i++) begin
      mask[i] = (TAKE_W'(i) >= {1'b0, bit_off}) && (TAKE_W'(i) < span_end);
    end
  end

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    a_nxt          = a_r;
    rem_nxt        = rem_r;
    clr_cnt_nxt    = clr_cnt_r;
    hit_nxt        = hit_r;
    miss_nxt       = miss_r;
    page_valid_nxt = page_valid_r;
    out_valid_nxt  = out_valid_r & ~out_pop;
    out_data_nxt   = out_data_r;
    q_pop          = 1'b0;
    ram_wr_en      = 1'b0;
    ram_wr_addr    = a_r[ADDR_WIDTH-1:BIT_W];
    ram_wr_data    = '0;
    ram_rd_en      = 1'b0;
    ram_rd_addr    = a_r[ADDR_WIDTH-1:BIT_W];
    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop       = 1'b1;
          op_nxt      = q_data.op;
          a_nxt       = q_data.addr;
          rem_nxt     = q_data.len;
          clr_cnt_nxt = '0;
          hit_nxt     = 1'b0;
          miss_nxt    = 1'b0;
          unique case (q_data.op)
            OP_CHECK: begin
              ram_rd_en   = 1'b1;
              ram_rd_addr = q_data.addr[ADDR_WIDTH-1:BIT_W];
              state_nxt   = ST_CHK_WAIT;
            end
            OP_ALLOC: begin
              state_nxt = page_valid_r[q_data.addr[ADDR_WIDTH-1:PAGE_SHIFT]] ?
                          ST_REPORT : ST_CLEAR;
            end
            OP_MARK, OP_UNMARK: begin
              state_nxt = (q_data.len == '0) ? ST_REPORT : ST_WALK;
            end
            default: state_nxt = ST_REPORT;
          endcase
        end
      end
      ST_CHK_WAIT: begin
        hit_nxt   = page_valid_r[cur_page] & ram_rd_data[bit_off];
        state_nxt = ST_REPORT;
      end
      ST_CLEAR: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = {cur_page, clr_cnt_r};
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == {PWORD_W{1'b1}}) begin
          page_valid_nxt[cur_page] = 1'b1;
          state_nxt                = ST_REPORT;
        end
      end
      ST_WALK: begin
        if (page_valid_r[cur_page]) begin
          ram_rd_en = 1'b1;
          state_nxt = ST_MODIFY;
        end else begin
          miss_nxt = 1'b1;
          a_nxt    = a_r + ADDR_WIDTH'(take);
          rem_nxt  = rem_r - LEN_W'(take);
          if (last_word) begin
            state_nxt = ST_REPORT;
          end
        end
      end
      ST_MODIFY: begin
        ram_wr_en   = 1'b1;
        ram_wr_data = (op_r == OP_MARK) ? (ram_rd_data | mask) : (ram_rd_data & ~mask);
        a_nxt       = a_r + ADDR_WIDTH'(take);
        rem_nxt     = rem_r - LEN_W'(take);
        state_nxt   = last_word ? ST_REPORT : ST_WALK;
      end
      ST_REPORT: begin
        if (!out_valid_r || out_pop) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.guard_hit    = hit_r;
          out_data_nxt.page_missing = miss_r;
          state_nxt                 = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      page_valid_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      page_valid_r <= page_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    a_r        <= a_nxt;
    rem_r      <= rem_nxt;
    clr_cnt_r  <= clr_cnt_nxt;
    hit_r      <= hit_nxt;
    miss_r     <= miss_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### dv/tb_guard_zone_shadow_bitmap_top.sv
// Self-checking testbench for guard_zone_shadow_bitmap_top: directed and random
// check, mark, unmark and allocate requests, scored against a bit-level shadow map.
// Depends on gzsb_pkg and the guard_zone_shadow_bitmap_top RTL.
module tb_guard_zone_shadow_bitmap_top import gzsb_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  // Run length and watchdog. A full-space mark walks 1024 words, and only a
  // handful of those are issued, so the limit is loose.
  localparam int RANDOM_REQS  = 480;
  localparam int BIG_RUNS     = 8;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int TAIL_CYCLES  = 100;
  localparam int HOLD_AFTER   = 150;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_EVERY  = 150;
  localparam int MAX_STARTS   = 16;
  localparam int PAGE_WORDS   = 1 << PWORD_W;

  typedef struct {
    in_item_t req;
    bit       drain_first;
  } pending_req_t;

  logic      clk;
  logic      rst_n   = 1'b0;
  logic      push    = 1'b0;
  logic      pop     = 1'b0;
  in_item_t  in_data = '0;
  logic      full;
  logic      empty;
  out_item_t out_data;

  // Shadow copy of the block's state: page flags and the guard bitmap.
  logic                 page_ok      [NUM_PAGES];
  logic [WORD_BITS-1:0] shadow_words [NUM_WORDS];

  pending_req_t          pending_reqs[$];
  out_item_t             expected_outcomes[$];
  logic [ADDR_WIDTH-1:0] mark_starts[$];

  int unsigned check_failures = 0;
  int unsigned results_seen   = 0;
  int unsigned cycle_count    = 0;
  int          burst_left     = 1;
  int          gap_left       = 0;
  int          hold_left      = 0;
  bit          hold_done      = 1'b0;
  int unsigned rx_phase       = 0;
  int          big_runs_left  = BIG_RUNS;

  guard_zone_shadow_bitmap_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_data  (in_data),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Applies one request to the shadow state and returns the result the block
  // must produce for it. Mark and unmark walk bit by bit with a wrapping
  // address counter, which is slow but obviously right.
  function automatic out_item_t predict_outcome(in_item_t req);
    out_item_t             res;
    op_t                   op;
    logic [ADDR_WIDTH-1:0] a;
    logic [LEN_W-1:0]      n;
    logic [PAGE_W-1:0]     pg;
    int unsigned           k;
    res = '0;
    op  = op_t'(req.command);
    pg  = req.address[ADDR_WIDTH-1:PAGE_SHIFT];
    case (op)
      OP_CHECK: begin
        // An invalid page never hits, whatever its stored bits are.
        if (page_ok[pg]) begin
          res.guard_hit = shadow_words[req.address[ADDR_WIDTH-1:BIT_W]][req.address[BIT_W-1:0]];
        end
      end
      OP_MARK, OP_UNMARK: begin
        // Start and length are rounded down to the 8-byte granule.
        a = req.address;
        a[GRAN_BITS-1:0] = '0;
        n = req.length;
        n[GRAN_BITS-1:0] = '0;
        for (k = 0; k < n; k++) begin
          if (page_ok[a[ADDR_WIDTH-1:PAGE_SHIFT]]) begin
            shadow_words[a[ADDR_WIDTH-1:BIT_W]][a[BIT_W-1:0]] = (op == OP_MARK);
          end else begin
            res.page_missing = 1'b1;
          end
          a = a + 1'b1;
        end
      end
      OP_ALLOC: begin
        // A page that is already valid keeps its bits.
        if (!page_ok[pg]) begin
          for (k = 0; k < PAGE_WORDS; k++) begin
            shadow_words[{pg, k[PWORD_W-1:0]}] = '0;
          end
          page_ok[pg] = 1'b1;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic void queue_req(op_t op, logic [ADDR_WIDTH-1:0] addr,
                                    logic [LEN_W-1:0] len, bit drain_first);
    pending_req_t p;
    p.req.command = op;
    p.req.address = addr;
    p.req.length  = len;
    p.drain_first = drain_first;
    pending_reqs.push_back(p);
  endfunction

  // Mostly short runs so the walk stays quick; a few span pages, and a
  // capped number reach up to the whole address space.
  function logic [LEN_W-1:0] pick_length();
    logic [LEN_W-1:0] len;
    int unsigned      roll;
    roll = $urandom_range(0, 99);
    if (roll < 6) begin
      len = LEN_W'($urandom_range(0, 7));
    end else if (roll < 85) begin
      len = LEN_W'($urandom_range(0, 512));
    end else if (roll < 97 || big_runs_left == 0) begin
      len = LEN_W'($urandom_range(0, 8192));
    end else begin
      big_runs_left--;
      len = LEN_W'($urandom_range(0, 65536));
    end
    return len;
  endfunction

  // Sender. A request is held while full is high. Between bursts of random
  // length it idles for a random gap, and a gap of zero gives back-to-back
  // bursts. A request marked drain_first waits until every result is back.
  always @(posedge clk) begin
    pending_req_t nxt;
    if (!rst_n) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        expected_outcomes.push_back(predict_outcome(in_data));
      end
      if (!push || !full) begin
        if (gap_left != 0) begin
          gap_left--;
          push <= 1'b0;
        end else if (pending_reqs.size() != 0 &&
                     !(pending_reqs[0].drain_first && expected_outcomes.size() != 0)) begin
          nxt = pending_reqs.pop_front();
          in_data <= nxt.req;
          push    <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Receiver. Each accepted result is scored against the oldest expectation.
  // Pop runs on a pattern of its own: a window with no stalls, then random
  // stalls. Once, after enough results, it holds off for a long stretch so the
  // block backs up and has to raise full while the sender keeps offering.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        results_seen++;
        if (expected_outcomes.size() == 0) begin
          $error("unexpected result: guard_hit %0b page_missing %0b",
                 out_data.guard_hit, out_data.page_missing);
          check_failures++;
        end else begin
          want = expected_outcomes.pop_front();
          if (out_data.guard_hit !== want.guard_hit) begin
            $error("guard_hit mismatch: expected %0b, actual %0b",
                   want.guard_hit, out_data.guard_hit);
            check_failures++;
          end
          if (out_data.page_missing !== want.page_missing) begin
            $error("page_missing mismatch: expected %0b, actual %0b",
                   want.page_missing, out_data.page_missing);
            check_failures++;
          end
        end
      end
      rx_phase = (rx_phase + 1) % 97;
      if (hold_left != 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (!hold_done && results_seen >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        pop <= 1'b0;
      end else if (rx_phase < 30) begin
        pop <= 1'b1;
      end else begin
        pop <= ($urandom_range(0, 2) != 0);
      end
    end
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int unsigned           i;
    int unsigned           roll;
    op_t                   op;
    logic [ADDR_WIDTH-1:0] addr;
    logic [LEN_W-1:0]      len;

    for (i = 0; i < NUM_PAGES; i++) page_ok[i] = 1'b0;
    for (i = 0; i < NUM_WORDS; i++) shadow_words[i] = '0;

    // Directed requests. Page 0 and page 15 get allocated; everything else
    // stays invalid so that page skipping and reporting are exercised.
    queue_req(OP_CHECK,  16'h0000, 17'h00000, 1'b0); // check of an invalid page
    queue_req(OP_MARK,   16'h0000, 17'h00040, 1'b0); // mark into an invalid page
    queue_req(OP_ALLOC,  16'h0ABC, 17'h00000, 1'b0); // allocate page 0
    queue_req(OP_CHECK,  16'h0000, 17'h00000, 1'b0); // fresh page reads clear
    queue_req(OP_MARK,   16'h0005, 17'h0000F, 1'b0); // unaligned start and length
    queue_req(OP_CHECK,  16'h0007, 17'h00000, 1'b0);
    queue_req(OP_CHECK,  16'h0008, 17'h00000, 1'b0);
    queue_req(OP_MARK,   16'h0100, 17'h00000, 1'b0); // zero length
    queue_req(OP_MARK,   16'h0100, 17'h00007, 1'b0); // rounds down to zero
    queue_req(OP_CHECK,  16'h0100, 17'h00000, 1'b0);
    queue_req(OP_ALLOC,  16'h0FFF, 17'h00000, 1'b0); // page 0 again: bits kept
    queue_req(OP_CHECK,  16'h0003, 17'h00000, 1'b0);
    queue_req(OP_ALLOC,  16'hFFFF, 17'h1FFFF & 17'h10000, 1'b0); // page 15
    queue_req(OP_MARK,   16'hFFF8, 17'h00010, 1'b0); // wraps past the top
    queue_req(OP_CHECK,  16'hFFFF, 17'h00000, 1'b0);
    queue_req(OP_CHECK,  16'h0000, 17'h00000, 1'b0);
    queue_req(OP_UNMARK, 16'h0FF8, 17'h00010, 1'b0); // crosses into invalid page 1
    queue_req(OP_CHECK,  16'h0FFF, 17'h00000, 1'b0);
    queue_req(OP_MARK,   16'hF000, 17'h10000, 1'b0); // whole address space
    queue_req(OP_CHECK,  16'h5555, 17'h00000, 1'b0);
    queue_req(OP_CHECK,  16'h0FFF, 17'h00000, 1'b0);
    queue_req(OP_UNMARK, 16'h0000, 17'h10000, 1'b0);
    queue_req(OP_CHECK,  16'hFFFF, 17'h00000, 1'b0);
    queue_req(OP_UNMARK, 16'hFFFF, 17'h0FFFF, 1'b0);

    // Random requests. Checks favor addresses near recent marks so that hits
    // and near misses both show up. Most allocations go to pages 0..11, which
    // keeps the upper pages invalid for a long time and page_missing alive.
    // Every so often a request waits for the block to drain completely.
    for (i = 0; i < RANDOM_REQS; i++) begin
      roll = $urandom_range(0, 99);
      addr = ADDR_WIDTH'($urandom());
      len  = LEN_W'($urandom_range(0, 65536));
      if (roll < 50) op = OP_CHECK;
      else if (roll < 72) op = OP_MARK;
      else if (roll < 87) op = OP_UNMARK;
      else op = OP_ALLOC;
      case (op)
        OP_CHECK: begin
          if (mark_starts.size() != 0 && $urandom_range(0, 9) < 6) begin
            addr = ADDR_WIDTH'(mark_starts[$urandom_range(0, mark_starts.size() - 1)] +
                               $urandom_range(0, 300));
          end
        end
        OP_MARK: begin
          len = pick_length();
          mark_starts.push_back(addr);
          if (mark_starts.size() > MAX_STARTS) void'(mark_starts.pop_front());
        end
        OP_UNMARK: begin
          len = pick_length();
          if (mark_starts.size() != 0 && $urandom_range(0, 1) == 0) begin
            addr = ADDR_WIDTH'(mark_starts[$urandom_range(0, mark_starts.size() - 1)] +
                               $urandom_range(0, 64));
          end
        end
        default: begin
          if ($urandom_range(0, 9) != 0) begin
            addr[ADDR_WIDTH-1:PAGE_SHIFT] = PAGE_W'($urandom_range(0, 11));
          end
        end
      endcase
      queue_req(op, addr, len, (i % DRAIN_EVERY) == 0);
    end

    // Synchronous reset, asserted from the start and never asserted again.
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Wait until every request is in and every result has been scored, then
    // give the block a short tail to show any stray result.
    while (pending_reqs.size() != 0 || push || expected_outcomes.size() != 0) begin
      @(posedge clk);
    end
    repeat (TAIL_CYCLES) @(posedge clk);

    if (check_failures == 0 && expected_outcomes.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
